// ----- sv/rle_dec_pkg.sv -----
// shared types and codes for the run-length byte stream decoder
`timescale 1ns / 1ps

package rle_dec_pkg;

   localparam int unsigned FrameWidth = 24;
   localparam logic [FrameWidth-1:0] FrameBytesReset = 24'd3110400;

   // kind of result loaded into the output register
   localparam logic [1:0] OUT_FAIL  = 2'd0;
   localparam logic [1:0] OUT_LIT   = 2'd1;
   localparam logic [1:0] OUT_CHUNK = 2'd2;

   // where the status field of a result comes from
   localparam logic [1:0] SEL_ZERO  = 2'd0;
   localparam logic [1:0] SEL_TRUNC = 2'd1;
   localparam logic [1:0] SEL_OVER  = 2'd2;
   localparam logic [1:0] SEL_END   = 2'd3;

   // status codes seen on the result channel
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_TRUNC = 2'd1;
   localparam logic [1:0] STS_OVER  = 2'd2;
   localparam logic [1:0] STS_SHORT = 2'd3;

   typedef struct packed {
      logic       restart;
      logic       ctrl_load;
      logic       lit_step;
      logic       run_start;
      logic       chunk_step;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_run_end;
      logic       out_done;
      logic [1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic room_short;
      logic lit_final;
      logic run_tail;
      logic is_run;
      logic out_busy;
   } stat_type;

endpackage

// ----- sv/rle_dec_dp.sv -----
// datapath: frame size, byte counters, run value and output register
`timescale 1ns / 1ps

module rle_dec_dp import rle_dec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [FrameWidth-1:0] csr_wr_data,
   input  logic [7:0]            req_packed_byte,
   input  logic                  rsp_ready,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte_0,
   output logic [7:0]            rsp_out_byte_1,
   output logic [7:0]            rsp_out_byte_2,
   output logic [7:0]            rsp_out_byte_3,
   output logic [2:0]            rsp_valid_count,
   output logic                  rsp_run_end,
   output logic                  rsp_frame_done,
   output logic [1:0]            rsp_status
);

   logic [FrameWidth-1:0] fb_ff, fb_in;
   logic [FrameWidth-1:0] bw_ff, bw_in;
   logic [7:0]            cnt_ff, cnt_in;
   logic [7:0]            val_ff, val_in;
   logic                  run_eq_ff, run_eq_in;

   logic                  valid_ff, valid_in;
   logic [7:0]            byte0_ff, byte0_in;
   logic [7:0]            byte1_ff, byte1_in;
   logic [7:0]            byte2_ff, byte2_in;
   logic [7:0]            byte3_ff, byte3_in;
   logic [2:0]            count_ff, count_in;
   logic                  run_end_ff, run_end_in;
   logic                  done_ff, done_in;
   logic [1:0]            status_ff, status_in;

   logic [7:0]            ctl_len;
   logic [FrameWidth:0]   need_sum;
   logic [FrameWidth-1:0] bw_plus_one;
   logic [FrameWidth-1:0] bw_plus_cnt;
   logic                  lit_eq;
   logic                  end_eq;
   logic [2:0]            chunk_n;
   logic [1:0]            sel_status;

   always_comb begin
      ctl_len     = req_packed_byte[7] ? ({1'b0, req_packed_byte[6:0]} + 8'd3)
                                       : (req_packed_byte + 8'd1);
      need_sum    = {1'b0, bw_ff} + {{(FrameWidth-7){1'b0}}, ctl_len};
      bw_plus_one = bw_ff + {{(FrameWidth-1){1'b0}}, 1'b1};
      bw_plus_cnt = bw_ff + {{(FrameWidth-8){1'b0}}, cnt_ff};
      lit_eq      = (bw_plus_one == fb_ff);
      chunk_n     = (cnt_ff <= 8'd4) ? cnt_ff[2:0] : 3'd4;

      stat.room_short = (bw_ff >= fb_ff) || (need_sum > {1'b0, fb_ff});
      stat.lit_final  = (cnt_ff == 8'd1);
      stat.run_tail   = (cnt_ff <= 8'd4);
      stat.is_run     = req_packed_byte[7];
      stat.out_busy   = valid_ff;
   end

   // bookkeeping registers
   always_comb begin
      fb_in     = csr_wr_en ? csr_wr_data : fb_ff;
      bw_in     = bw_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      run_eq_in = run_eq_ff;
      if (cmd.ctrl_load) begin
         cnt_in = ctl_len;
      end
      if (cmd.lit_step) begin
         bw_in  = bw_plus_one;
         cnt_in = cnt_ff - 8'd1;
      end
      if (cmd.run_start) begin
         bw_in     = bw_plus_cnt;
         val_in    = req_packed_byte;
         run_eq_in = (bw_plus_cnt == fb_ff);
      end
      if (cmd.chunk_step) begin
         cnt_in = cnt_ff - {5'd0, chunk_n};
      end
      if (cmd.restart) begin
         bw_in  = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff  <= FrameBytesReset;
         bw_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         fb_ff  <= fb_in;
         bw_ff  <= bw_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      run_eq_ff <= run_eq_in;
   end

   // output register
   always_comb begin
      end_eq = (cmd.out_kind == OUT_CHUNK) ? run_eq_ff : lit_eq;
      case (cmd.out_sel)
         SEL_ZERO:  sel_status = STS_OK;
         SEL_TRUNC: sel_status = STS_TRUNC;
         SEL_OVER:  sel_status = STS_OVER;
         SEL_END:   sel_status = end_eq ? STS_OK : STS_SHORT;
         default:   sel_status = STS_OK;
      endcase

      valid_in   = valid_ff && !rsp_ready;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      byte2_in   = byte2_ff;
      byte3_in   = byte3_ff;
      count_in   = count_ff;
      run_end_in = run_end_ff;
      done_in    = done_ff;
      status_in  = status_ff;
      if (cmd.out_load) begin
         valid_in   = 1'b1;
         run_end_in = cmd.out_run_end;
         done_in    = cmd.out_done;
         status_in  = sel_status;
         case (cmd.out_kind)
            OUT_LIT: begin
               byte0_in = req_packed_byte;
               byte1_in = '0;
               byte2_in = '0;
               byte3_in = '0;
               count_in = 3'd1;
            end
            OUT_CHUNK: begin
               byte0_in = val_ff;
               byte1_in = (chunk_n > 3'd1) ? val_ff : 8'd0;
               byte2_in = (chunk_n > 3'd2) ? val_ff : 8'd0;
               byte3_in = (chunk_n > 3'd3) ? val_ff : 8'd0;
               count_in = chunk_n;
            end
            default: begin
               byte0_in = '0;
               byte1_in = '0;
               byte2_in = '0;
               byte3_in = '0;
               count_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff   <= byte0_in;
      byte1_ff   <= byte1_in;
      byte2_ff   <= byte2_in;
      byte3_ff   <= byte3_in;
      count_ff   <= count_in;
      run_end_ff <= run_end_in;
      done_ff    <= done_in;
      status_ff  <= status_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte_0  = byte0_ff;
   assign rsp_out_byte_1  = byte1_ff;
   assign rsp_out_byte_2  = byte2_ff;
   assign rsp_out_byte_3  = byte3_ff;
   assign rsp_valid_count = count_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_status      = status_ff;

endmodule

// ----- sv/rle_dec_ctrl.sv -----
// controller: decode mode state machine and run chunk sequencing
`timescale 1ns / 1ps

module rle_dec_ctrl import rle_dec_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stream_last,
   output logic     req_ready,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_CTRL    = 3'd0;
   localparam logic [2:0] S_RUNVAL  = 3'd1;
   localparam logic [2:0] S_LIT     = 3'd2;
   localparam logic [2:0] S_DISCARD = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       slot_free;
   logic       accept;

   always_comb begin
      slot_free = !stat.out_busy || rsp_ready;
      req_ready = (state_ff != S_EMIT) && slot_free;
      accept    = req_valid && req_ready;

      state_in        = state_ff;
      last_in         = last_ff;
      cmd             = '0;
      cmd.out_kind    = OUT_FAIL;
      cmd.out_sel     = SEL_ZERO;

      case (state_ff)
         S_CTRL: begin
            if (accept) begin
               if (req_stream_last) begin
                  cmd.out_load    = 1'b1;
                  cmd.out_run_end = 1'b1;
                  cmd.out_done    = 1'b1;
                  cmd.out_sel     = SEL_TRUNC;
                  cmd.restart     = 1'b1;
               end else if (stat.room_short) begin
                  cmd.out_load    = 1'b1;
                  cmd.out_run_end = 1'b1;
                  cmd.out_done    = 1'b1;
                  cmd.out_sel     = SEL_OVER;
                  cmd.restart     = 1'b1;
                  state_in        = S_DISCARD;
               end else begin
                  cmd.ctrl_load = 1'b1;
                  state_in      = stat.is_run ? S_RUNVAL : S_LIT;
               end
            end
         end
         S_RUNVAL: begin
            if (accept) begin
               cmd.run_start = 1'b1;
               last_in       = req_stream_last;
               state_in      = S_EMIT;
            end
         end
         S_LIT: begin
            if (accept) begin
               cmd.lit_step    = 1'b1;
               cmd.out_load    = 1'b1;
               cmd.out_kind    = OUT_LIT;
               cmd.out_run_end = 1'b1;
               cmd.out_done    = req_stream_last;
               if (stat.lit_final) begin
                  cmd.out_sel = req_stream_last ? SEL_END : SEL_ZERO;
                  state_in    = S_CTRL;
               end else if (req_stream_last) begin
                  // literal cut short: earlier bytes stay delivered
                  cmd.out_sel = SEL_TRUNC;
                  state_in    = S_CTRL;
               end
               cmd.restart = req_stream_last;
            end
         end
         S_DISCARD: begin
            if (accept && req_stream_last) begin
               cmd.restart = 1'b1;
               state_in    = S_CTRL;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.chunk_step  = 1'b1;
               cmd.out_load    = 1'b1;
               cmd.out_kind    = OUT_CHUNK;
               cmd.out_run_end = stat.run_tail;
               cmd.out_done    = stat.run_tail && last_ff;
               cmd.out_sel     = (stat.run_tail && last_ff) ? SEL_END : SEL_ZERO;
               if (stat.run_tail) begin
                  cmd.restart = last_ff;
                  state_in    = S_CTRL;
               end
            end
         end
         default: begin
            state_in = S_CTRL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CTRL;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ----- sv/rle_byte_stream_decoder_unit.sv -----
// top level of the run-length byte stream decoder
//
// req channel: one packed byte per transaction, req_stream_last on the final
// byte of a frame. rsp channel: up to four decoded bytes per transaction with
// rsp_valid_count, rsp_run_end, rsp_frame_done and rsp_status. csr_wr_en with
// csr_wr_data sets the expected decoded frame size; write it only when idle.
// A literal or error result leaves from an output register in the cycle after
// the transaction that causes it; a run's chunks follow its run value byte.
// Literals stream at one byte per cycle while the receiver keeps up. A run
// value byte yields up to 33 chunks of up to four bytes; the chunk sequencer
// holds req_ready low while it drains. An error at a control byte gives one
// zero-byte result, then input is dropped up to the last byte of the frame;
// an error found at a literal or run value byte rides on a data result.
// When the receiver stalls, the result holds in the output register and the
// next byte is taken only once that register frees up.
// Synchronous reset empties the output register, restarts the frame and
// loads the default frame size of 3110400 bytes.
`timescale 1ns / 1ps

module rle_byte_stream_decoder_unit import rle_dec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [FrameWidth-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_packed_byte,
   input  logic                  req_stream_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte_0,
   output logic [7:0]            rsp_out_byte_1,
   output logic [7:0]            rsp_out_byte_2,
   output logic [7:0]            rsp_out_byte_3,
   output logic [2:0]            rsp_valid_count,
   output logic                  rsp_run_end,
   output logic                  rsp_frame_done,
   output logic [1:0]            rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   rle_dec_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stream_last (req_stream_last),
      .req_ready       (req_ready),
      .rsp_ready       (rsp_ready),
      .stat            (stat),
      .cmd             (cmd)
   );

   rle_dec_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_packed_byte (req_packed_byte),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte_0  (rsp_out_byte_0),
      .rsp_out_byte_1  (rsp_out_byte_1),
      .rsp_out_byte_2  (rsp_out_byte_2),
      .rsp_out_byte_3  (rsp_out_byte_3),
      .rsp_valid_count (rsp_valid_count),
      .rsp_run_end     (rsp_run_end),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- sv/rle_dec_checker.sv -----
// port-level checker for the run-length byte stream decoder, with its bind
`timescale 1ns / 1ps

module rle_dec_checker import rle_dec_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_valid_count,
   input logic       rsp_run_end,
   input logic       rsp_frame_done,
   input logic [1:0] rsp_status
);

   // output register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_count))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_count <= 3'd4)
      else $error("byte count above four");

   // status is only reported on a finished frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_status == STS_OK)
      else $error("status set on an open frame");

   // an empty result is always an error report that closes the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_valid_count == 3'd0) |->
         rsp_frame_done && rsp_run_end && (rsp_status != STS_OK))
      else $error("empty result that is not an error report");

endmodule

bind rle_byte_stream_decoder_unit rle_dec_checker u_rle_dec_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_valid_count (rsp_valid_count),
   .rsp_run_end     (rsp_run_end),
   .rsp_frame_done  (rsp_frame_done),
   .rsp_status      (rsp_status)
);
